// ===== rtl/core/srpwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srpwm_pkg;

   localparam int CHANNELS = 32;
   localparam int CH_AW    = 5;
   localparam int PIX_AW   = 6;
   localparam int LEVEL_W  = 8;
   localparam int KIND_W   = 3;
   localparam int FRAME_W  = 32;
   localparam int STEP_OUT_W = 7;

   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WIDTH  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FILL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd4;

   localparam logic [CH_AW-1:0] SCRAMBLE [CHANNELS] = '{
      5'd3,  5'd2,  5'd29, 5'd28, 5'd31, 5'd30, 5'd25, 5'd24,
      5'd27, 5'd26, 5'd21, 5'd20, 5'd23, 5'd22, 5'd17, 5'd16,
      5'd19, 5'd18, 5'd13, 5'd12, 5'd15, 5'd14, 5'd9,  5'd8,
      5'd11, 5'd10, 5'd5,  5'd4,  5'd7,  5'd6,  5'd1,  5'd0
   };
   localparam logic [CH_AW-1:0] ROW_CHAN [8] = '{
      5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16
   };
   localparam logic [CH_AW-1:0] COL_CHAN [8] = '{
      5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24
   };

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_COPY,
      ST_FRAME,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               sw_we;
      logic [CH_AW-1:0]   sw_waddr;
      logic [LEVEL_W-1:0] sw_wdata;
      logic               lw_we;
      logic [CH_AW-1:0]   lw_waddr;
      logic [LEVEL_W-1:0] lw_wdata;
      logic               sp_we;
      logic [PIX_AW-1:0]  sp_waddr;
      logic [LEVEL_W-1:0] sp_wdata;
      logic               lp_we;
      logic [PIX_AW-1:0]  lp_waddr;
      logic [LEVEL_W-1:0] lp_wdata;
      logic [CH_AW-1:0]   sw_raddr;
      logic [PIX_AW-1:0]  sp_raddr;
      logic [CH_AW-1:0]   lw_raddr;
      logic [PIX_AW-1:0]  lp_raddr;
   } store_cmd_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] sw_q;
      logic [LEVEL_W-1:0] sp_q;
      logic [LEVEL_W-1:0] lw_q;
      logic [LEVEL_W-1:0] lp_q;
   } store_data_type;

   typedef struct packed {
      logic                  valid;
      logic [FRAME_W-1:0]    frame;
      logic [STEP_OUT_W-1:0] step;
      logic                  period_end;
   } emit_type;

endpackage

`default_nettype wire

// ===== rtl/core/srpwm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srpwm_store #(
   parameter int PIX_AW = 6
) (
   input  wire                        clock,
   input  srpwm_pkg::store_cmd_type   cmd,
   output srpwm_pkg::store_data_type  rd
);

   localparam int PIX_DEPTH = 2 ** PIX_AW;

   logic [srpwm_pkg::LEVEL_W-1:0] sw_mem [srpwm_pkg::CHANNELS];
   logic [srpwm_pkg::LEVEL_W-1:0] lw_mem [srpwm_pkg::CHANNELS];
   logic [srpwm_pkg::LEVEL_W-1:0] sp_mem [PIX_DEPTH];
   logic [srpwm_pkg::LEVEL_W-1:0] lp_mem [PIX_DEPTH];

   srpwm_pkg::store_data_type rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.sw_we) begin
         sw_mem[cmd.sw_waddr] <= cmd.sw_wdata;
      end
      if (cmd.lw_we) begin
         lw_mem[cmd.lw_waddr] <= cmd.lw_wdata;
      end
      if (cmd.sp_we) begin
         sp_mem[cmd.sp_waddr[PIX_AW-1:0]] <= cmd.sp_wdata;
      end
      if (cmd.lp_we) begin
         lp_mem[cmd.lp_waddr[PIX_AW-1:0]] <= cmd.lp_wdata;
      end
      rd_ff.sw_q <= sw_mem[cmd.sw_raddr];
      rd_ff.lw_q <= lw_mem[cmd.lw_raddr];
      rd_ff.sp_q <= sp_mem[cmd.sp_raddr[PIX_AW-1:0]];
      rd_ff.lp_q <= lp_mem[cmd.lp_raddr[PIX_AW-1:0]];
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srpwm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srpwm_ctrl #(
   parameter int ROWS         = 8,
   parameter int COLS         = 8,
   parameter int ROW_STEPS    = 12,
   parameter int PERIOD_STEPS = 96
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire  [srpwm_pkg::KIND_W-1:0]         req_kind,
   input  wire  [srpwm_pkg::CH_AW-1:0]          req_channel,
   input  wire  [2:0]                           req_row,
   input  wire  [2:0]                           req_col,
   input  wire  [srpwm_pkg::LEVEL_W-1:0]        req_level,
   output logic                                 req_stall,
   input  wire                                  out_ready,
   output srpwm_pkg::emit_type                  emit,
   output srpwm_pkg::store_cmd_type             cmd,
   input  srpwm_pkg::store_data_type            rd
);

   localparam int PIX    = ROWS * COLS;
   localparam int SWEEP  = (PIX > srpwm_pkg::CHANNELS) ? PIX : srpwm_pkg::CHANNELS;
   localparam int CNT_W  = $clog2(SWEEP + 1);
   localparam int STEP_W = $clog2(PERIOD_STEPS);
   localparam int SUB_W  = (ROW_STEPS > 1) ? $clog2(ROW_STEPS) : 1;

   srpwm_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  cnt_prev;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] active_ff, active_in;
   logic [SUB_W-1:0]  sub_ff, sub_in;
   logic              pending_ff, pending_in;
   logic [srpwm_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [srpwm_pkg::CHANNELS-1:0] chan_ff, chan_in;
   logic [COLS-1:0]   col_ff, col_in;
   logic [COLS:0]     col_shift;
   logic              col_hit;
   logic [srpwm_pkg::CHANNELS-1:0] chan_on;
   logic [srpwm_pkg::FRAME_W-1:0]  frame_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= srpwm_pkg::ST_CLEAR;
         cnt_ff     <= '0;
         step_ff    <= '0;
         active_ff  <= '0;
         sub_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         step_ff    <= step_in;
         active_ff  <= active_in;
         sub_ff     <= sub_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      chan_ff  <= chan_in;
      col_ff   <= col_in;
   end

   // Row and column channels override the width compare of their channel.
   always_comb begin
      chan_on    = chan_ff;
      frame_word = '0;
      for (int r = 0; r < ROWS; r++) begin
         chan_on[srpwm_pkg::ROW_CHAN[r]] = (32'(active_ff) != r);
      end
      for (int j = 0; j < COLS; j++) begin
         chan_on[srpwm_pkg::COL_CHAN[j]] = (32'(active_ff) < ROWS) && col_ff[j];
      end
      for (int c = 0; c < srpwm_pkg::CHANNELS; c++) begin
         frame_word[srpwm_pkg::SCRAMBLE[c]] = chan_on[c];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      sub_in     = sub_ff;
      pending_in = pending_ff;
      level_in   = level_ff;
      chan_in    = chan_ff;
      col_in     = col_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      cnt_prev   = cnt_ff - 1'b1;
      col_hit    = 8'(sub_ff) < rd.lp_q;
      col_shift  = {col_hit, col_ff} >> 1;

      emit.valid      = 1'b0;
      emit.frame      = frame_word;
      emit.step       = 7'(step_ff);
      emit.period_end = (step_ff == STEP_W'(PERIOD_STEPS - 1));

      unique case (state_ff)
         srpwm_pkg::ST_CLEAR: begin
            cmd.sw_we    = cnt_ff < CNT_W'(srpwm_pkg::CHANNELS);
            cmd.lw_we    = cnt_ff < CNT_W'(srpwm_pkg::CHANNELS);
            cmd.sw_waddr = 5'(cnt_ff);
            cmd.lw_waddr = 5'(cnt_ff);
            cmd.sp_we    = cnt_ff < CNT_W'(PIX);
            cmd.lp_we    = cnt_ff < CNT_W'(PIX);
            cmd.sp_waddr = 6'(cnt_ff);
            cmd.lp_waddr = 6'(cnt_ff);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SWEEP - 1)) begin
               state_in = srpwm_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end
         srpwm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_kind)
                  srpwm_pkg::KIND_TICK: begin
                     cnt_in = '0;
                     if (step_ff == '0 && pending_ff) begin
                        state_in = srpwm_pkg::ST_COPY;
                     end else begin
                        state_in = srpwm_pkg::ST_FRAME;
                     end
                  end
                  srpwm_pkg::KIND_WIDTH: begin
                     cmd.sw_we    = 1'b1;
                     cmd.sw_waddr = req_channel;
                     cmd.sw_wdata = req_level;
                  end
                  srpwm_pkg::KIND_PIXEL: begin
                     cmd.sp_we    = (32'(req_row) < ROWS) && (32'(req_col) < COLS);
                     cmd.sp_waddr = 6'(32'(req_row) * COLS + 32'(req_col));
                     cmd.sp_wdata = req_level;
                  end
                  srpwm_pkg::KIND_FILL: begin
                     level_in = req_level;
                     cnt_in   = '0;
                     state_in = srpwm_pkg::ST_FILL;
                  end
                  srpwm_pkg::KIND_COMMIT: begin
                     pending_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         srpwm_pkg::ST_FILL: begin
            cmd.sp_we    = 1'b1;
            cmd.sp_waddr = 6'(cnt_ff);
            cmd.sp_wdata = level_ff;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PIX - 1)) begin
               state_in = srpwm_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end
         srpwm_pkg::ST_COPY: begin
            cmd.sw_raddr = 5'(cnt_ff);
            cmd.sp_raddr = 6'(cnt_ff);
            if (cnt_ff != '0) begin
               cmd.lw_we    = cnt_prev < CNT_W'(srpwm_pkg::CHANNELS);
               cmd.lw_waddr = 5'(cnt_prev);
               cmd.lw_wdata = rd.sw_q;
               cmd.lp_we    = cnt_prev < CNT_W'(PIX);
               cmd.lp_waddr = 6'(cnt_prev);
               cmd.lp_wdata = rd.sp_q;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SWEEP)) begin
               state_in   = srpwm_pkg::ST_FRAME;
               cnt_in     = '0;
               pending_in = 1'b0;
            end
         end
         srpwm_pkg::ST_FRAME: begin
            cmd.lw_raddr = 5'(cnt_ff);
            cmd.lp_raddr = 6'(32'(active_ff) * COLS + 32'(cnt_ff));
            if (cnt_ff != '0) begin
               chan_in = {9'(step_ff) < 9'(rd.lw_q), chan_ff[srpwm_pkg::CHANNELS-1:1]};
               if (cnt_prev < CNT_W'(COLS)) begin
                  col_in = col_shift[COLS-1:0];
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(srpwm_pkg::CHANNELS)) begin
               state_in = srpwm_pkg::ST_EMIT;
               cnt_in   = '0;
            end
         end
         srpwm_pkg::ST_EMIT: begin
            emit.valid = out_ready;
            if (out_ready) begin
               state_in = srpwm_pkg::ST_IDLE;
               if (step_ff == STEP_W'(PERIOD_STEPS - 1)) begin
                  step_in   = '0;
                  sub_in    = '0;
                  active_in = '0;
               end else begin
                  step_in = step_ff + 1'b1;
                  if (sub_ff == SUB_W'(ROW_STEPS - 1)) begin
                     sub_in    = '0;
                     active_in = active_ff + 1'b1;
                  end else begin
                     sub_in = sub_ff + 1'b1;
                  end
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/shift_register_pwm_matrix_frames.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   kind, channel, row, col, level
// rsp       out        rsp_valid/rsp_stall   frame, step, period_end
//
// Width, pixel and commit words act in idle; a fill writes every pixel entry.
// A tick reads the live width memory one channel at a time through its single
// read port; a tick that applies a commit first copies staged data to live.
// After reset a clearing pass over every memory entry holds req_stall.
// The result register lets the next word in while a frame waits on rsp_stall.

module shift_register_pwm_matrix_frames #(
   parameter int ROWS         = 8,
   parameter int COLS         = 8,
   parameter int ROW_STEPS    = 12,
   parameter int PERIOD_STEPS = 96
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [srpwm_pkg::KIND_W-1:0]          req_kind,
   input  wire  [srpwm_pkg::CH_AW-1:0]           req_channel,
   input  wire  [2:0]                            req_row,
   input  wire  [2:0]                            req_col,
   input  wire  [srpwm_pkg::LEVEL_W-1:0]         req_level,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [srpwm_pkg::FRAME_W-1:0]         rsp_frame,
   output logic [srpwm_pkg::STEP_OUT_W-1:0]      rsp_step,
   output logic                                  rsp_period_end
);

   localparam int PIX    = ROWS * COLS;
   localparam int PIX_AW = (PIX > 1) ? $clog2(PIX) : 1;

   srpwm_pkg::store_cmd_type  cmd;
   srpwm_pkg::store_data_type rd;
   srpwm_pkg::emit_type       emit;

   logic out_ready;
   logic rsp_valid_ff, rsp_valid_in;
   logic [srpwm_pkg::FRAME_W-1:0]    rsp_frame_ff;
   logic [srpwm_pkg::STEP_OUT_W-1:0] rsp_step_ff;
   logic                             rsp_period_end_ff;

   srpwm_ctrl #(
      .ROWS         (ROWS),
      .COLS         (COLS),
      .ROW_STEPS    (ROW_STEPS),
      .PERIOD_STEPS (PERIOD_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_channel (req_channel),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_level   (req_level),
      .req_stall   (req_stall),
      .out_ready   (out_ready),
      .emit        (emit),
      .cmd         (cmd),
      .rd          (rd)
   );

   srpwm_store #(
      .PIX_AW (PIX_AW)
   ) u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_frame_ff      <= emit.frame;
         rsp_step_ff       <= emit.step;
         rsp_period_end_ff <= emit.period_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame      = rsp_frame_ff;
   assign rsp_step       = rsp_step_ff;
   assign rsp_period_end = rsp_period_end_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srpwm_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srpwm_check #(
   parameter int PERIOD_STEPS = 96
) (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [31:0] rsp_frame,
   input wire [6:0]  rsp_step,
   input wire        rsp_period_end
);

   logic       have_ff, have_in;
   logic [6:0] next_ff, next_in;

   always_comb begin
      have_in = have_ff;
      next_in = next_ff;
      if (rsp_valid && !rsp_stall) begin
         have_in = 1'b1;
         next_in = rsp_period_end ? 7'd0 : rsp_step + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         next_ff <= '0;
      end else begin
         have_ff <= have_in;
         next_ff <= next_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_clear: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during the clearing pass");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame) && $stable(rsp_step))
      else $error("stalled result changed");

   a_end_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_end |-> rsp_step == 7'(PERIOD_STEPS - 1))
      else $error("period end flagged on a wrong step");

   a_step_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && have_ff |-> rsp_step == next_ff)
      else $error("step sequence broken");

endmodule

bind shift_register_pwm_matrix_frames srpwm_check #(
   .PERIOD_STEPS (PERIOD_STEPS)
) u_srpwm_check (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame      (rsp_frame),
   .rsp_step       (rsp_step),
   .rsp_period_end (rsp_period_end)
);

`default_nettype wire

// ===== dv/shift_register_pwm_matrix_frames_tb.sv =====
`timescale 1ns / 1ps

module shift_register_pwm_matrix_frames_tb;

   localparam int ROWS         = 8;
   localparam int COLS         = 8;
   localparam int ROW_STEPS    = 12;
   localparam int PERIOD_STEPS = 96;
   localparam logic [srpwm_pkg::KIND_W-1:0] KIND_SPARE = 3'd5;

   typedef struct {
      logic [srpwm_pkg::KIND_W-1:0]  kind;
      logic [srpwm_pkg::CH_AW-1:0]   channel;
      logic [2:0]                    row;
      logic [2:0]                    col;
      logic [srpwm_pkg::LEVEL_W-1:0] level;
   } req_word_type;

   typedef struct {
      logic [srpwm_pkg::FRAME_W-1:0]    frame;
      logic [srpwm_pkg::STEP_OUT_W-1:0] step;
      logic                             period_end;
   } frame_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [srpwm_pkg::KIND_W-1:0] req_kind = '0;
   logic [srpwm_pkg::CH_AW-1:0] req_channel = '0;
   logic [2:0] req_row = '0;
   logic [2:0] req_col = '0;
   logic [srpwm_pkg::LEVEL_W-1:0] req_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [srpwm_pkg::FRAME_W-1:0] rsp_frame;
   logic [srpwm_pkg::STEP_OUT_W-1:0] rsp_step;
   logic rsp_period_end;

   req_word_type words_to_send[$];
   frame_word_type frames_due[$];

   logic [srpwm_pkg::LEVEL_W-1:0] staged_width [srpwm_pkg::CHANNELS];
   logic [srpwm_pkg::LEVEL_W-1:0] live_width [srpwm_pkg::CHANNELS];
   logic [srpwm_pkg::LEVEL_W-1:0] staged_pixel [ROWS*COLS];
   logic [srpwm_pkg::LEVEL_W-1:0] live_pixel [ROWS*COLS];
   int pwm_step = 0;
   logic commit_armed = 1'b0;

   int errors = 0;
   int cycle_no = 0;
   logic calm;
   int send_gap = 0;
   int stall_left = 0;
   logic send_now;
   logic stall_now;
   req_word_type next_word;

   always #5 clock = ~clock;

   shift_register_pwm_matrix_frames uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_channel   (req_channel),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_level     (req_level),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_frame     (rsp_frame),
      .rsp_step      (rsp_step),
      .rsp_period_end(rsp_period_end)
   );

   assign calm = (cycle_no % 3000) < 600;

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [srpwm_pkg::FRAME_W-1:0] pwm_frame(int s);
      logic [srpwm_pkg::FRAME_W-1:0] w;
      int active;
      int sub;
      w = '0;
      active = s / ROW_STEPS;
      sub = s % ROW_STEPS;
      for (int c = 0; c < srpwm_pkg::CHANNELS; c++) begin
         w[srpwm_pkg::SCRAMBLE[c]] = s < live_width[c];
      end
      for (int r = 0; r < ROWS; r++) begin
         w[srpwm_pkg::SCRAMBLE[srpwm_pkg::ROW_CHAN[r]]] = r != active;
      end
      for (int j = 0; j < COLS; j++) begin
         w[srpwm_pkg::SCRAMBLE[srpwm_pkg::COL_CHAN[j]]] =
            active < ROWS && sub < live_pixel[active*COLS + j];
      end
      return w;
   endfunction

   task automatic apply_word(req_word_type w);
      frame_word_type f;
      int s;
      case (w.kind)
         srpwm_pkg::KIND_TICK: begin
            s = (pwm_step >= PERIOD_STEPS) ? 0 : pwm_step;
            if (s == 0 && commit_armed) begin
               live_width = staged_width;
               live_pixel = staged_pixel;
               commit_armed = 1'b0;
            end
            f.frame = pwm_frame(s);
            f.step = s[srpwm_pkg::STEP_OUT_W-1:0];
            f.period_end = s == PERIOD_STEPS - 1;
            frames_due.push_back(f);
            pwm_step = (s + 1 >= PERIOD_STEPS) ? 0 : s + 1;
         end
         srpwm_pkg::KIND_WIDTH: begin
            staged_width[w.channel] = w.level;
         end
         srpwm_pkg::KIND_PIXEL: begin
            if (w.row < ROWS && w.col < COLS) begin
               staged_pixel[w.row*COLS + w.col] = w.level;
            end
         end
         srpwm_pkg::KIND_FILL: begin
            foreach (staged_pixel[i]) staged_pixel[i] = w.level;
         end
         srpwm_pkg::KIND_COMMIT: begin
            commit_armed = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_word(logic [srpwm_pkg::KIND_W-1:0] kind,
                           logic [srpwm_pkg::CH_AW-1:0] channel,
                           logic [2:0] row, logic [2:0] col,
                           logic [srpwm_pkg::LEVEL_W-1:0] level);
      req_word_type w;
      w.kind = kind;
      w.channel = channel;
      w.row = row;
      w.col = col;
      w.level = level;
      words_to_send.push_back(w);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         send_now = req_valid;
         if (req_valid && !req_stall) begin
            next_word.kind = req_kind;
            next_word.channel = req_channel;
            next_word.row = req_row;
            next_word.col = req_col;
            next_word.level = req_level;
            apply_word(next_word);
            send_now = 1'b0;
            send_gap = pick_gap();
         end
         if (!send_now) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (words_to_send.size() > 0) begin
               next_word = words_to_send.pop_front();
               req_kind <= next_word.kind;
               req_channel <= next_word.channel;
               req_row <= next_word.row;
               req_col <= next_word.col;
               req_level <= next_word.level;
               send_now = 1'b1;
            end
         end
         req_valid <= send_now;
      end
   end

   always @(posedge clock) begin
      frame_word_type f;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $display("%0t unexpected frame word %h step %0d", $time, rsp_frame, rsp_step);
               errors++;
            end else begin
               f = frames_due.pop_front();
               if (rsp_frame !== f.frame) begin
                  $display("%0t frame expected %h actual %h", $time, f.frame, rsp_frame);
                  errors++;
               end
               if (rsp_step !== f.step) begin
                  $display("%0t step expected %0d actual %0d", $time, f.step, rsp_step);
                  errors++;
               end
               if (rsp_period_end !== f.period_end) begin
                  $display("%0t period_end expected %b actual %b", $time, f.period_end,
                           rsp_period_end);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap();
         end
         stall_now = stall_left > 0;
         rsp_stall <= stall_now;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int r;
      logic [srpwm_pkg::LEVEL_W-1:0] lvl;
      foreach (staged_width[i]) begin
         staged_width[i] = '0;
         live_width[i] = '0;
      end
      foreach (staged_pixel[i]) begin
         staged_pixel[i] = '0;
         live_pixel[i] = '0;
      end

      add_word(srpwm_pkg::KIND_TICK, 5'd0, 3'd0, 3'd0, 8'd0);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd0, 3'd7, 3'd7, 8'd255);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd31, 3'd0, 3'd0, 8'd255);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd15, 3'd0, 3'd0, 8'd1);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd7, 3'd0, 3'd0, 8'd0);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd16, 3'd0, 3'd0, 8'd96);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd23, 3'd0, 3'd0, 8'd95);
      add_word(srpwm_pkg::KIND_FILL, 5'd31, 3'd7, 3'd7, 8'd255);
      add_word(srpwm_pkg::KIND_PIXEL, 5'd0, 3'd0, 3'd0, 8'd0);
      add_word(srpwm_pkg::KIND_PIXEL, 5'd0, 3'd7, 3'd7, 8'd12);
      add_word(srpwm_pkg::KIND_PIXEL, 5'd0, 3'd3, 3'd5, 8'd1);
      add_word(srpwm_pkg::KIND_COMMIT, 5'd0, 3'd0, 3'd0, 8'd0);
      add_word(srpwm_pkg::KIND_WIDTH, 5'd8, 3'd0, 3'd0, 8'd50);
      add_word(srpwm_pkg::KIND_PIXEL, 5'd0, 3'd7, 3'd0, 8'd255);
      add_word(srpwm_pkg::KIND_TICK, 5'd31, 3'd7, 3'd7, 8'd255);
      add_word(KIND_SPARE, 5'd31, 3'd7, 3'd7, 8'd255);
      add_word(KIND_SPARE + 3'd1, 5'd0, 3'd0, 3'd0, 8'd0);
      add_word(KIND_SPARE + 3'd2, 5'd21, 3'd5, 3'd2, 8'd170);
      add_word(srpwm_pkg::KIND_TICK, 5'd0, 3'd0, 3'd0, 8'd0);

      // Ticks dominate so that commits land on several period starts.
      for (int n = 0; n < 500; n++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) begin
            lvl = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end else if ($urandom_range(0, 1)) begin
            lvl = 8'($urandom_range(0, 100));
         end else begin
            lvl = 8'($urandom_range(0, 255));
         end
         add_word(r < 60 ? srpwm_pkg::KIND_TICK :
                  r < 75 ? srpwm_pkg::KIND_WIDTH :
                  r < 87 ? srpwm_pkg::KIND_PIXEL :
                  r < 90 ? srpwm_pkg::KIND_FILL :
                  r < 95 ? srpwm_pkg::KIND_COMMIT :
                  KIND_SPARE + 3'($urandom_range(0, 2)),
                  5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), lvl);
      end

      @(posedge clock);
      while (words_to_send.size() > 0 || req_valid || frames_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
